// ===== src/udec_pkg.sv =====
`default_nettype none
package udec_pkg;

  // Characters that steer the decoder.
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;

  // Largest number of bytes a single input item can produce.
  localparam int RecBytes = 6;

  // Default depth of the queue between front and back.
  localparam int QueueDepth = 4;

  // Escape phase of the front part.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2,
    PH_UNI  = 2'd3
  } phase_t;

  // Result of classifying a byte as a hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Everything one input item produces, as handed from front to back.
  typedef struct packed {
    logic [RecBytes-1:0][7:0] bytes;
    logic [2:0]               n;
    logic                     last;
    logic                     bare;
  } rec_t;

  // Hex digit decode: only 0-9, A-F and a-f count.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== src/url_percent_decoder.sv =====
// URL percent decoder.
// Input channel: in_valid / in_stall with in_byte and text_last; text_last
// marks the final byte of a text. Output channel: out_valid / out_stall with
// out_byte, has_byte, run_end and text_end. An item moves on a rising edge
// where valid is high and stall is low.
// Each input byte yields zero to six output items; run_end flags the last
// output item of an input byte, text_end the last one of the text. A final
// byte that yields nothing gives one marker item with has_byte low.
// The front part classifies one byte per cycle while the queue has room and
// writes a record of its results into a small queue; the back part plays the
// records out one item per cycle while out_stall is low. A record is first
// registered in the queue. Sustained rate is one input byte per cycle while
// each byte yields at most one output item and out_stall is low; otherwise
// the back part sets the pace. in_stall rises only when the queue is full, so
// a stalled receiver backs up through the queue with nothing lost.
// Reset is synchronous: it empties the queue and leaves the decoder with no
// escape pending.
`default_nettype none
module url_percent_decoder
  import udec_pkg::*;
#(
  parameter int QDepth = QueueDepth
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            run_end,
  output logic            text_end
);

  logic push;
  rec_t push_rec;
  logic q_full;
  logic pop;
  rec_t head;
  logic head_valid;

  udec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .text_last (text_last),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  udec_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  udec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_end    (run_end),
    .text_end   (text_end)
  );

endmodule
`default_nettype wire

// ===== src/udec_front.sv =====
`default_nettype none
module udec_front
  import udec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_last,
  input  wire logic       q_full,
  output logic            push,
  output rec_t            push_rec
);

  phase_t      phase, phase_next;
  logic [7:0]  held [3];
  logic [7:0]  held_next [3];
  logic [1:0]  dcnt, dcnt_next;
  logic [11:0] code, code_next;

  logic        accept;
  logic [7:0]  lst [RecBytes];
  logic [2:0]  n;
  hex_t        hx;
  logic [15:0] cp;
  logic        brk;
  logic        plain;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // Escape state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      dcnt  <= 2'd0;
      code  <= 12'd0;
    end else if (accept) begin
      phase <= phase_next;
      dcnt  <= dcnt_next;
      code  <= code_next;
    end
  end

  // Held escape digits carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  // Next state and the list of bytes this item produces.
  always_comb begin
    phase_next = phase;
    held_next  = held;
    dcnt_next  = dcnt;
    code_next  = code;
    n          = 3'd0;
    for (int k = 0; k < RecBytes; k++) lst[k] = 8'd0;
    hx    = hex_decode(in_byte);
    cp    = {code, hx.val};
    brk   = 1'b0;

    case (phase)
      PH_PCT: begin
        if (in_byte == ChU) begin
          phase_next = PH_UNI;
          dcnt_next  = 2'd0;
          code_next  = 12'd0;
        end else if (hx.ok) begin
          phase_next   = PH_HEX;
          held_next[0] = in_byte;
          dcnt_next    = 2'd1;
          code_next    = {8'd0, hx.val};
        end else begin
          brk = 1'b1;
        end
      end
      PH_HEX: begin
        if (hx.ok) begin
          lst[n]     = {code[3:0], hx.val};
          n          = n + 3'd1;
          phase_next = PH_IDLE;
          dcnt_next  = 2'd0;
          code_next  = 12'd0;
        end else begin
          brk = 1'b1;
        end
      end
      PH_UNI: begin
        if (hx.ok) begin
          if (dcnt != 2'd3) begin
            held_next[dcnt] = in_byte;
            dcnt_next       = dcnt + 2'd1;
            code_next       = {code[7:0], hx.val};
          end else begin
            // Full code point: encode as UTF-8, surrogates give nothing.
            if (cp < 16'h0080) begin
              lst[n] = {1'b0, cp[6:0]};
              n      = n + 3'd1;
            end else if (cp < 16'h0800) begin
              lst[n] = {3'b110, cp[10:6]};
              n      = n + 3'd1;
              lst[n] = {2'b10, cp[5:0]};
              n      = n + 3'd1;
            end else if (cp[15:11] != 5'b11011) begin
              lst[n] = {4'b1110, cp[15:12]};
              n      = n + 3'd1;
              lst[n] = {2'b10, cp[11:6]};
              n      = n + 3'd1;
              lst[n] = {2'b10, cp[5:0]};
              n      = n + 3'd1;
            end
            phase_next = PH_IDLE;
            dcnt_next  = 2'd0;
            code_next  = 12'd0;
          end
        end else begin
          brk = 1'b1;
        end
      end
      default: ;
    endcase

    plain = brk | (phase == PH_IDLE);

    // A broken escape gives back its characters literally.
    if (brk) begin
      lst[n] = ChPct;
      n      = n + 3'd1;
      if (phase == PH_UNI) begin
        lst[n] = ChU;
        n      = n + 3'd1;
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < dcnt) begin
          lst[n] = held[k];
          n      = n + 3'd1;
        end
      end
      phase_next = PH_IDLE;
      dcnt_next  = 2'd0;
      code_next  = 12'd0;
    end

    // Ordinary text handling of the current byte.
    if (plain) begin
      if (in_byte == ChPct) begin
        phase_next = PH_PCT;
        dcnt_next  = 2'd0;
        code_next  = 12'd0;
      end else if (in_byte == ChPlus) begin
        lst[n] = ChSpace;
        n      = n + 3'd1;
      end else begin
        lst[n] = in_byte;
        n      = n + 3'd1;
      end
    end

    // At end of text a pending escape is flushed as literal characters.
    if (text_last && (phase_next != PH_IDLE)) begin
      lst[n] = ChPct;
      n      = n + 3'd1;
      if (phase_next == PH_UNI) begin
        lst[n] = ChU;
        n      = n + 3'd1;
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < dcnt_next) begin
          lst[n] = held_next[k];
          n      = n + 3'd1;
        end
      end
      phase_next = PH_IDLE;
      dcnt_next  = 2'd0;
      code_next  = 12'd0;
    end
  end

  // Record for the back part; an empty final item becomes a bare marker.
  always_comb begin
    for (int k = 0; k < RecBytes; k++) push_rec.bytes[k] = lst[k];
    push_rec.bare = (n == 3'd0);
    push_rec.n    = (n == 3'd0) ? 3'd1 : n;
    push_rec.last = text_last;
  end

  assign push = accept & ((n != 3'd0) | text_last);

endmodule
`default_nettype wire

// ===== src/udec_fifo.sv =====
`default_nettype none
module udec_fifo
  import udec_pkg::*;
#(
  parameter int Depth = QueueDepth
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      full,
  input  wire logic pop,
  output rec_t      head,
  output logic      head_valid
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;

  // Full depends on the stored count only, so the stall path stays registered.
  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/udec_back.sv =====
`default_nettype none
module udec_back
  import udec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rec_t       head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            run_end,
  output logic            text_end
);

  logic [2:0] idx;
  logic       take;

  assign out_valid = head_valid;
  assign take      = head_valid & ~out_stall;

  // Present one byte of the head record at a time.
  assign out_byte = head.bytes[idx];
  assign has_byte = ~head.bare;
  assign run_end  = (idx == head.n - 3'd1);
  assign text_end = run_end & head.last;
  assign pop      = take & run_end;

  // Byte index within the head record.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (take) begin
      idx <= run_end ? 3'd0 : idx + 3'd1;
    end
  end

endmodule
`default_nettype wire
